// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/psnm_pkg.sv =====
// Package: constants, codes and controller/datapath link types
`default_nettype none
package psnm_pkg;

  localparam int SHADE_ROWS   = 32;
  localparam int PALETTE_SIZE = 256;
  localparam int IDX_W        = $clog2(PALETTE_SIZE);
  localparam int SUM_W        = 10;
  localparam int COLOUR_W     = 24;
  localparam int SRT_W        = SUM_W + IDX_W;
  localparam int DIST_W       = 18;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SORT   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [4:0] ROW_LAST  = (SHADE_ROWS > 32) ? 5'd31 : 5'(SHADE_ROWS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PALETTE_SIZE - 1);

  // x*11/160 = ((x*11) >> 5) / 5; /5 by reciprocal 3277 / 2^14
  localparam logic [3:0]  SCALE_NUM   = 4'd11;
  localparam logic [11:0] RECIP_5     = 12'd3277;
  localparam int          RECIP_SHIFT = 14;
  localparam logic [7:0]  CHAN_MAX    = 8'd255;
  localparam logic [10:0] SUM_WINDOW  = 11'd40;

  typedef enum logic [1:0] {PAL_SEL_IDX, PAL_SEL_ENTRY, PAL_SEL_ORD} pal_sel_t;
  typedef enum logic [1:0] {SRT_SEL_I, SRT_SEL_J, SRT_SEL_P} srt_sel_t;

  typedef struct packed {
    logic     cap;
    logic     pal_we;
    logic     pal_re;
    pal_sel_t pal_sel;
    logic     srt_we;
    logic     srt_re;
    srt_sel_t srt_sel;
    logic     srt_wr_init;
    logic     i_clr;
    logic     i_inc;
    logic     j_load;
    logic     j_inc;
    logic     p_inc;
    logic     cur_load;
    logic     cur_swap;
    logic     scale_mul;
    logic     scale_div;
    logic     scan_init;
    logic     take_default;
    logic     dist_update;
    logic     load_out;
    logic     order_ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       i_last;
    logic       j_last;
    logic       p_last;
    logic       below;
    logic       above;
    logic       cur_gt;
    logic       out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== design/psnm_chan_if.sv =====
// Handshake channel interfaces for request and response beats
`default_nettype none
interface psnm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [4:0] shade_row;
  modport source (output valid, op, entry_index, red, green, blue, shade_row, input ready);
  modport sink (input valid, op, entry_index, red, green, blue, shade_row, output ready);
endinterface

interface psnm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;
  logic       found;
  modport source (output valid, palette_index, found, input ready);
  modport sink (input valid, palette_index, found, output ready);
endinterface
`default_nettype wire

// ===== design/psnm_ram.sv =====
// Generic single-write, single-read RAM with registered read
`default_nettype none
module psnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== design/psnm_ctrl.sv =====
// Controller: sequences write, sort and lookup over the datapath
`default_nettype none
module psnm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire psnm_pkg::status_t sts,
  output psnm_pkg::cmd_t         cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INIT_RD, S_INIT_WR, S_SRT_LD_RD, S_SRT_LD, S_SRT_RD,
    S_SRT_CMP, S_SRT_WB, S_LK_RD, S_LK_MUL, S_LK_DIV, S_SC_RD, S_SC_CHK,
    S_SC_DIST, S_DONE
  } state_t;

  state_t state, state_next;
  logic   order_ready, order_ready_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      order_ready <= 1'b0;
    end else begin
      state       <= state_next;
      order_ready <= order_ready_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd              = '0;
    cmd.pal_sel      = psnm_pkg::PAL_SEL_IDX;
    cmd.srt_sel      = psnm_pkg::SRT_SEL_I;
    cmd.order_ok     = order_ready;
    state_next       = state;
    order_ready_next = order_ready;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          psnm_pkg::OP_WRITE: begin
            cmd.pal_we       = 1'b1;
            order_ready_next = 1'b0;
            state_next       = S_IDLE;
          end
          psnm_pkg::OP_SORT: begin
            cmd.i_clr  = 1'b1;
            state_next = S_INIT_RD;
          end
          psnm_pkg::OP_LOOKUP: begin
            state_next = order_ready ? S_LK_RD : S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_INIT_RD: begin
        cmd.pal_re = 1'b1;
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.srt_we      = 1'b1;
        cmd.srt_wr_init = 1'b1;
        if (sts.i_last) begin
          cmd.i_clr  = 1'b1;
          state_next = S_SRT_LD_RD;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_INIT_RD;
        end
      end
      S_SRT_LD_RD: begin
        cmd.srt_re = 1'b1;
        cmd.j_load = 1'b1;
        state_next = S_SRT_LD;
      end
      S_SRT_LD: begin
        cmd.cur_load = 1'b1;
        state_next   = sts.i_last ? S_SRT_WB : S_SRT_RD;
      end
      S_SRT_RD: begin
        cmd.srt_re  = 1'b1;
        cmd.srt_sel = psnm_pkg::SRT_SEL_J;
        state_next  = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        cmd.srt_sel = psnm_pkg::SRT_SEL_J;
        if (sts.cur_gt) begin
          cmd.srt_we   = 1'b1;
          cmd.cur_swap = 1'b1;
        end
        if (sts.j_last) begin
          state_next = S_SRT_WB;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_SRT_RD;
        end
      end
      S_SRT_WB: begin
        cmd.srt_we = 1'b1;
        if (sts.i_last) begin
          order_ready_next = 1'b1;
          state_next       = S_IDLE;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_SRT_LD_RD;
        end
      end
      S_LK_RD: begin
        cmd.pal_re  = 1'b1;
        cmd.pal_sel = psnm_pkg::PAL_SEL_ENTRY;
        state_next  = S_LK_MUL;
      end
      S_LK_MUL: begin
        cmd.scale_mul = 1'b1;
        state_next    = S_LK_DIV;
      end
      S_LK_DIV: begin
        cmd.scale_div = 1'b1;
        cmd.scan_init = 1'b1;
        state_next    = S_SC_RD;
      end
      S_SC_RD: begin
        cmd.srt_re  = 1'b1;
        cmd.srt_sel = psnm_pkg::SRT_SEL_P;
        state_next  = S_SC_CHK;
      end
      S_SC_CHK: begin
        cmd.take_default = 1'b1;
        cmd.pal_sel      = psnm_pkg::PAL_SEL_ORD;
        if (sts.below) begin
          if (sts.p_last) begin
            state_next = S_DONE;
          end else begin
            cmd.p_inc  = 1'b1;
            state_next = S_SC_RD;
          end
        end else if (sts.above) begin
          state_next = S_DONE;
        end else begin
          cmd.pal_re = 1'b1;
          state_next = S_SC_DIST;
        end
      end
      S_SC_DIST: begin
        cmd.dist_update = 1'b1;
        if (sts.p_last) begin
          state_next = S_DONE;
        end else begin
          cmd.p_inc  = 1'b1;
          state_next = S_SC_RD;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/psnm_dp.sv =====
// Datapath: palette and sorted-table RAMs, scaling, window scan, result register
`default_nettype none
module psnm_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire psnm_pkg::cmd_t   cmd,
  output psnm_pkg::status_t     sts,
  input  wire logic [1:0]       in_op,
  input  wire logic [7:0]       in_entry,
  input  wire logic [7:0]       in_red,
  input  wire logic [7:0]       in_green,
  input  wire logic [7:0]       in_blue,
  input  wire logic [4:0]       in_row,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_index,
  output logic                  out_found
);
  localparam int IW = psnm_pkg::IDX_W;
  localparam int SW = psnm_pkg::SUM_W;

  // captured beat
  logic [1:0]  op_q;
  logic [IW-1:0] entry_q;
  logic [23:0] rgb_q;
  logic [4:0]  row_q;

  // counters
  logic [IW-1:0] idx_i, idx_j, idx_p;

  // RAM ports
  logic [IW-1:0] pal_raddr, srt_addr;
  logic [23:0]   pal_rdata;
  logic [psnm_pkg::SRT_W-1:0] srt_wdata, srt_rdata, cur;

  // scaling and scan
  logic [11:0] q_r, q_g, q_b;
  logic [7:0]  sc_r, sc_g, sc_b;
  logic [SW:0] total;
  logic [SW-1:0] s_rd;
  logic [IW-1:0] ord_rd;
  logic [psnm_pkg::DIST_W-1:0] sq_dist, best_d;
  logic [IW-1:0] best_ord;
  logic found_q;
  logic [9:0] pal_sum;

  function automatic logic [11:0] scale_pre(input logic [7:0] v, input logic [4:0] row);
    logic [16:0] prod;
    prod = 17'(v * row) * 17'(psnm_pkg::SCALE_NUM);
    return prod[16:5];
  endfunction

  function automatic logic [7:0] scale_post(input logic [11:0] q);
    logic [23:0] m;
    logic [9:0]  d;
    m = q * psnm_pkg::RECIP_5;
    d = m[psnm_pkg::RECIP_SHIFT +: 10];
    return (d > 10'(psnm_pkg::CHAN_MAX)) ? psnm_pkg::CHAN_MAX : d[7:0];
  endfunction

  function automatic logic [16:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic signed [8:0] df;
    logic [8:0] mag;
    df  = $signed({1'b0, a}) - $signed({1'b0, b});
    mag = df[8] ? 9'(-df) : df;
    return 17'(mag * mag);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q    <= in_op;
      entry_q <= in_entry;
      rgb_q   <= {in_red, in_green, in_blue};
      row_q   <= (in_row > psnm_pkg::ROW_LAST) ? psnm_pkg::ROW_LAST : in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.i_clr) begin
      idx_i <= '0;
    end else if (cmd.i_inc) begin
      idx_i <= idx_i + 1'b1;
    end
    if (cmd.j_load) begin
      idx_j <= idx_i + 1'b1;
    end else if (cmd.j_inc) begin
      idx_j <= idx_j + 1'b1;
    end
    if (cmd.scan_init) begin
      idx_p <= '0;
    end else if (cmd.p_inc) begin
      idx_p <= idx_p + 1'b1;
    end
  end

  always_comb begin
    case (cmd.pal_sel)
      psnm_pkg::PAL_SEL_ENTRY: pal_raddr = entry_q;
      psnm_pkg::PAL_SEL_ORD:   pal_raddr = ord_rd;
      default:                 pal_raddr = idx_i;
    endcase
    case (cmd.srt_sel)
      psnm_pkg::SRT_SEL_J: srt_addr = idx_j;
      psnm_pkg::SRT_SEL_P: srt_addr = idx_p;
      default:             srt_addr = idx_i;
    endcase
  end

  assign pal_sum   = 10'(pal_rdata[23:16]) + 10'(pal_rdata[15:8]) + 10'(pal_rdata[7:0]);
  assign srt_wdata = cmd.srt_wr_init ? {pal_sum, idx_i} : cur;

  psnm_ram #(.WIDTH(psnm_pkg::COLOUR_W), .DEPTH(psnm_pkg::PALETTE_SIZE)) u_pal_ram (
    .clk   (clk),
    .we    (cmd.pal_we),
    .waddr (entry_q),
    .wdata (rgb_q),
    .re    (cmd.pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  psnm_ram #(.WIDTH(psnm_pkg::SRT_W), .DEPTH(psnm_pkg::PALETTE_SIZE)) u_srt_ram (
    .clk   (clk),
    .we    (cmd.srt_we),
    .waddr (srt_addr),
    .wdata (srt_wdata),
    .re    (cmd.srt_re),
    .raddr (srt_addr),
    .rdata (srt_rdata)
  );

  assign s_rd   = srt_rdata[psnm_pkg::SRT_W-1 -: SW];
  assign ord_rd = srt_rdata[IW-1:0];

  // running element of the exchange sort
  always_ff @(posedge clk) begin
    if (cmd.cur_load || cmd.cur_swap) begin
      cur <= srt_rdata;
    end
  end

  // channel scaling, two registered stages
  always_ff @(posedge clk) begin
    if (cmd.scale_mul) begin
      q_r <= scale_pre(pal_rdata[23:16], row_q);
      q_g <= scale_pre(pal_rdata[15:8], row_q);
      q_b <= scale_pre(pal_rdata[7:0], row_q);
    end
    if (cmd.scale_div) begin
      sc_r <= scale_post(q_r);
      sc_g <= scale_post(q_g);
      sc_b <= scale_post(q_b);
    end
  end

  assign total   = 11'(sc_r) + 11'(sc_g) + 11'(sc_b);
  assign sq_dist = psnm_pkg::DIST_W'(sq_diff(pal_rdata[23:16], sc_r))
                 + psnm_pkg::DIST_W'(sq_diff(pal_rdata[15:8], sc_g))
                 + psnm_pkg::DIST_W'(sq_diff(pal_rdata[7:0], sc_b));

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      found_q <= 1'b0;
    end else if (cmd.dist_update && (!found_q || sq_dist < best_d)) begin
      found_q <= 1'b1;
    end
    if (cmd.take_default && idx_p == '0) begin
      best_ord <= ord_rd;
    end else if (cmd.dist_update && (!found_q || sq_dist < best_d)) begin
      best_ord <= ord_rd;
      best_d   <= sq_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_index <= best_ord;
      out_found <= found_q;
    end
  end

  always_comb begin
    sts.op       = op_q;
    sts.i_last   = (idx_i == psnm_pkg::IDX_LAST);
    sts.j_last   = (idx_j == psnm_pkg::IDX_LAST);
    sts.p_last   = (idx_p == psnm_pkg::IDX_LAST);
    sts.below    = ((11'(s_rd) + psnm_pkg::SUM_WINDOW) < total);
    sts.above    = (11'(s_rd) > (total + psnm_pkg::SUM_WINDOW));
    sts.cur_gt   = (cur[psnm_pkg::SRT_W-1 -: SW] > s_rd);
    sts.out_busy = out_valid && !out_ready;
  end
endmodule
`default_nettype wire

// ===== design/palette_shade_nearest_match_top.sv =====
// Top level: palette shade nearest-match block, controller plus datapath
// Write beat: the palette RAM is written in the decode state. Sort beat: an exchange sort,
// each compare going through one port of the sorted table.
// Lookup beat: read the entry, scale it, then scan; each scanned entry reads the sorted
// table, then the palette RAM only when it falls inside the window.
// Reset (rst, synchronous) idles the controller, drops the sorted-order flag and the
// response valid; RAM contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module palette_shade_nearest_match_top (
  input wire logic   clk,
  input wire logic   rst,
  psnm_req_if.sink   req,
  psnm_rsp_if.source rsp
);
  psnm_pkg::cmd_t    cmd;
  psnm_pkg::status_t sts;
  logic              req_ready;

  assign req.ready = req_ready;

  // controller: one FSM, owns the sorted-order flag
  psnm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: RAMs, counters, scaler, distance unit and the response register
  psnm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (req.op),
    .in_entry  (req.entry_index),
    .in_red    (req.red),
    .in_green  (req.green),
    .in_blue   (req.blue),
    .in_row    (req.shade_row),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_index (rsp.palette_index),
    .out_found (rsp.found)
  );

  // a response is only produced by a lookup against a sorted table
  `ASSERT_IMPL(a_load_needs_order, cmd.load_out, cmd.order_ok)
  // the request side is closed while a response is being loaded
  `ASSERT_IMPL(a_load_not_ready, cmd.load_out, !req.ready)
  // response valid rises only from a controller load
  `ASSERT_IMPL(a_valid_from_load, $rose(rsp.valid), $past(cmd.load_out))
  // after a load the response is presented
  `ASSERT_NEXT(a_load_shows, cmd.load_out, rsp.valid)
endmodule
`default_nettype wire
